// ----- hw/rtl/bpb_pkg.sv -----
// ----------------------------------------------------------------------------
// bpb_pkg
// Shared types and constants for the BMP pixel blit core.
// ----------------------------------------------------------------------------
`default_nettype none

package bpb_pkg;

  // Largest image side in pixels; widths below follow from it.
  localparam int MAX_SIDE = 4096;
  localparam int SIDE_W   = $clog2(MAX_SIDE + 1);  // holds 1..MAX_SIDE
  localparam int CNT_W    = $clog2(MAX_SIDE);      // holds 0..MAX_SIDE-1

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [31:0] ALPHA_OPAQUE = 32'hff00_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PIXEL_MODE   = 3'd0,
    REG_IMAGE_WIDTH  = 3'd1,
    REG_IMAGE_HEIGHT = 3'd2,
    REG_DEST_X       = 3'd3,
    REG_DEST_Y       = 3'd4,
    REG_LINE_PIXELS  = 3'd5,
    REG_FRAME_BASE   = 3'd6
  } cfg_reg_t;

  localparam logic MODE_BGR24  = 1'b0;
  localparam logic MODE_ARGB32 = 1'b1;

  // Register contents plus the clamped image sides.
  typedef struct packed {
    logic              pixel_mode;
    logic [SIDE_W-1:0] width;
    logic [SIDE_W-1:0] height;
    logic [11:0]       dest_x;
    logic [11:0]       dest_y;
    logic [13:0]       line_pixels;
    logic [31:0]       frame_base;
  } cfg_t;

  // One assembled pixel with its source position.
  typedef struct packed {
    logic [31:0]      word;
    logic [CNT_W-1:0] column;
    logic [CNT_W-1:0] row;
    logic             last;
  } pix_t;

endpackage

`default_nettype wire

// ----- hw/rtl/bpb_if.sv -----
// ----------------------------------------------------------------------------
// bpb_if
// Valid/ready channel interfaces for the byte input and the pixel writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface bpb_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface bpb_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] write_address;
  logic [31:0] pixel_word;
  logic        last_pixel;

  modport source (output valid, output write_address, output pixel_word,
                  output last_pixel, input ready);
  modport sink   (input valid, input write_address, input pixel_word,
                  input last_pixel, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/bmp_pixel_blit_core.sv -----
// ----------------------------------------------------------------------------
// bmp_pixel_blit_core
// Turns the byte stream of a bottom-up BMP pixel array into ARGB framebuffer
// writes, one write per completed pixel.
// ----------------------------------------------------------------------------
// Throughput: one input byte per clock cycle, sustained, as long as the
//   result side keeps taking words.
// Pipeline: three register stages (assembly, row multiply, address sum),
//   which a result word passes through in that order.
// Reset: synchronous, active low; clears the stream position, all valid flags
//   and the registers to their documented defaults.
`default_nettype none

module bmp_pixel_blit_core
  import bpb_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  bpb_in_if.sink                     in_bus,
  bpb_out_if.source                  out_bus,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wr_data
);

  // The register file holds the blit geometry. Width and height leave it
  // already clamped to 1..MAX_SIDE, so downstream logic never sees zero.
  cfg_t cfg;

  bpb_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_wr_en),
    .wr_index (cfg_index),
    .wr_data  (cfg_wr_data),
    .cfg      (cfg)
  );

  // The assembler consumes every accepted byte at once: padding bytes and
  // partial pixels only update its state. It stalls the input only while it
  // holds a finished pixel that the address pipeline cannot take this cycle,
  // because the next byte might complete another pixel.
  logic in_fire;
  logic asm_busy;
  logic pix_valid;
  logic pix_ready;
  pix_t pix;

  assign in_bus.ready = !asm_busy;
  assign in_fire      = in_bus.valid && in_bus.ready;

  bpb_assembler u_assembler (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_fire   (in_fire),
    .in_byte   (in_bus.data_byte),
    .adv       (pix_ready),
    .busy      (asm_busy),
    .pix_valid (pix_valid),
    .pix       (pix)
  );

  // The address pipeline forms the row offset (row times line pitch) and base
  // plus column offset in one stage and sums them in the next. Each stage moves
  // forward whenever the stage after it is empty or draining, so a bubble anywhere
  // is filled and a waiting output word blocks input only once both stages are full.
  bpb_addr_pipe u_addr_pipe (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .pix_valid     (pix_valid),
    .pix           (pix),
    .pix_ready     (pix_ready),
    .out_valid     (out_bus.valid),
    .out_ready     (out_bus.ready),
    .write_address (out_bus.write_address),
    .pixel_word    (out_bus.pixel_word),
    .last_pixel    (out_bus.last_pixel)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/bpb_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// bpb_cfg_regs
// Configuration register file; presents width and height clamped to range.
// ----------------------------------------------------------------------------
`default_nettype none

module bpb_cfg_regs
  import bpb_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  wr_en,
  input  wire logic [CFG_IDX_W-1:0]  wr_index,
  input  wire logic [CFG_DATA_W-1:0] wr_data,
  output cfg_t                       cfg
);

  logic        pixel_mode_r;
  logic [12:0] width_r;
  logic [12:0] height_r;
  logic [11:0] dest_x_r;
  logic [11:0] dest_y_r;
  logic [13:0] line_pixels_r;
  logic [31:0] frame_base_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pixel_mode_r  <= MODE_BGR24;
      width_r       <= 13'd1;
      height_r      <= 13'd1;
      dest_x_r      <= '0;
      dest_y_r      <= '0;
      line_pixels_r <= 14'd1024;
      frame_base_r  <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_PIXEL_MODE:   pixel_mode_r  <= wr_data[0];
        REG_IMAGE_WIDTH:  width_r       <= wr_data[12:0];
        REG_IMAGE_HEIGHT: height_r      <= wr_data[12:0];
        REG_DEST_X:       dest_x_r      <= wr_data[11:0];
        REG_DEST_Y:       dest_y_r      <= wr_data[11:0];
        REG_LINE_PIXELS:  line_pixels_r <= wr_data[13:0];
        REG_FRAME_BASE:   frame_base_r  <= wr_data[31:0];
        default: ;
      endcase
    end
  end

  function automatic logic [SIDE_W-1:0] clamp_side(input logic [12:0] v);
    logic [SIDE_W-1:0] r;
    if (v == '0) begin
      r = SIDE_W'(1);
    end else if (32'(v) > 32'(MAX_SIDE)) begin
      r = SIDE_W'(MAX_SIDE);
    end else begin
      r = SIDE_W'(v);
    end
    return r;
  endfunction

  always_comb begin
    cfg.pixel_mode  = pixel_mode_r;
    cfg.width       = clamp_side(width_r);
    cfg.height      = clamp_side(height_r);
    cfg.dest_x      = dest_x_r;
    cfg.dest_y      = dest_y_r;
    cfg.line_pixels = line_pixels_r;
    cfg.frame_base  = frame_base_r;
  end

endmodule

`default_nettype wire

// ----- hw/rtl/bpb_assembler.sv -----
// ----------------------------------------------------------------------------
// bpb_assembler
// Gathers bytes into pixels, skips row padding and tracks column and row.
// ----------------------------------------------------------------------------
`default_nettype none

module bpb_assembler
  import bpb_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire cfg_t       cfg,
  input  wire logic       in_fire,
  input  wire logic [7:0] in_byte,
  input  wire logic       adv,       // downstream takes the held pixel
  output logic            busy,      // a pixel is held and not yet taken
  output logic            pix_valid,
  output pix_t            pix
);

  logic [1:0]       byte_slot_r,    byte_slot_nxt;
  logic [23:0]      pixel_bytes_r,  pixel_bytes_nxt;
  logic [CNT_W-1:0] column_r,       column_nxt;
  logic [CNT_W-1:0] row_r,          row_nxt;
  logic [1:0]       pad_left_r,     pad_left_nxt;
  logic             pix_valid_r,    pix_valid_nxt;
  pix_t             pix_r,          pix_nxt;

  logic done;
  logic row_end;
  logic img_end;

  always_comb begin
    byte_slot_nxt   = byte_slot_r;
    pixel_bytes_nxt = pixel_bytes_r;
    column_nxt      = column_r;
    row_nxt         = row_r;
    pad_left_nxt    = pad_left_r;
    pix_nxt         = pix_r;
    pix_valid_nxt   = pix_valid_r && !adv;

    done    = (cfg.pixel_mode == MODE_ARGB32) ? (byte_slot_r == 2'd3)
                                              : (byte_slot_r >= 2'd2);
    row_end = ({1'b0, column_r} + 1'b1) >= cfg.width;
    img_end = row_end && (({1'b0, row_r} + 1'b1) >= cfg.height);

    if (in_fire) begin
      pix_valid_nxt = 1'b0;
      if (pad_left_r != 2'd0) begin
        pad_left_nxt = pad_left_r - 2'd1;
      end else if (!done) begin
        unique case (byte_slot_r)
          2'd0:    pixel_bytes_nxt[7:0]   = in_byte;
          2'd1:    pixel_bytes_nxt[15:8]  = in_byte;
          default: pixel_bytes_nxt[23:16] = in_byte;
        endcase
        byte_slot_nxt = byte_slot_r + 2'd1;
      end else begin
        if (cfg.pixel_mode == MODE_ARGB32) begin
          pix_nxt.word = {in_byte, pixel_bytes_r};
        end else begin
          pix_nxt.word = ALPHA_OPAQUE | {8'h00, in_byte, pixel_bytes_r[15:0]};
        end
        pix_nxt.column  = column_r;
        pix_nxt.row     = row_r;
        pix_nxt.last    = img_end;
        pix_valid_nxt   = 1'b1;
        byte_slot_nxt   = 2'd0;
        pixel_bytes_nxt = '0;
        if (row_end) begin
          column_nxt   = '0;
          row_nxt      = img_end ? '0 : row_r + 1'b1;
          pad_left_nxt = (cfg.pixel_mode == MODE_ARGB32) ? 2'd0 : cfg.width[1:0];
        end else begin
          column_nxt = column_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_slot_r   <= '0;
      pixel_bytes_r <= '0;
      column_r      <= '0;
      row_r         <= '0;
      pad_left_r    <= '0;
      pix_valid_r   <= 1'b0;
    end else begin
      byte_slot_r   <= byte_slot_nxt;
      pixel_bytes_r <= pixel_bytes_nxt;
      column_r      <= column_nxt;
      row_r         <= row_nxt;
      pad_left_r    <= pad_left_nxt;
      pix_valid_r   <= pix_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pix_r <= pix_nxt;
  end

  assign busy      = pix_valid_r && !adv;
  assign pix_valid = pix_valid_r;
  assign pix       = pix_r;

endmodule

`default_nettype wire

// ----- hw/rtl/bpb_addr_pipe.sv -----
// ----------------------------------------------------------------------------
// bpb_addr_pipe
// Two-stage address pipeline: row multiply, then final sum into the output.
// ----------------------------------------------------------------------------
`default_nettype none

module bpb_addr_pipe
  import bpb_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire cfg_t         cfg,
  input  wire logic         pix_valid,
  input  wire pix_t         pix,
  output logic              pix_ready,
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic [31:0]       write_address,
  output logic [31:0]       pixel_word,
  output logic              last_pixel
);

  // Multiply stage.
  logic        m_valid_r,  m_valid_nxt;
  logic [31:0] m_row_off_r, m_row_off_nxt;
  logic [31:0] m_col_off_r, m_col_off_nxt;
  logic [31:0] m_word_r;
  logic        m_last_r;

  // Output stage.
  logic        o_valid_r, o_valid_nxt;
  logic [31:0] o_addr_r;
  logic [31:0] o_word_r;
  logic        o_last_r;

  logic        o_ready;
  logic        m_ready;
  logic [31:0] dst_row;

  assign o_ready   = !o_valid_r || out_ready;
  assign m_ready   = !m_valid_r || o_ready;
  assign pix_ready = m_ready;

  always_comb begin
    // Wraps modulo 2^32 when the row count overruns a shrunken height.
    dst_row       = 32'(cfg.dest_y) + 32'(cfg.height) - 32'd1 - 32'(pix.row);
    m_row_off_nxt = (dst_row * 32'(cfg.line_pixels)) << 2;
    m_col_off_nxt = cfg.frame_base + ((32'(cfg.dest_x) + 32'(pix.column)) << 2);
    m_valid_nxt   = m_ready ? pix_valid : m_valid_r;
    o_valid_nxt   = o_ready ? m_valid_r : o_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_valid_r <= 1'b0;
      o_valid_r <= 1'b0;
    end else begin
      m_valid_r <= m_valid_nxt;
      o_valid_r <= o_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (m_ready && pix_valid) begin
      m_row_off_r <= m_row_off_nxt;
      m_col_off_r <= m_col_off_nxt;
      m_word_r    <= pix.word;
      m_last_r    <= pix.last;
    end
    if (o_ready && m_valid_r) begin
      o_addr_r <= m_col_off_r + m_row_off_r;
      o_word_r <= m_word_r;
      o_last_r <= m_last_r;
    end
  end

  assign out_valid     = o_valid_r;
  assign write_address = o_addr_r;
  assign pixel_word    = o_word_r;
  assign last_pixel    = o_last_r;

endmodule

`default_nettype wire
